// ===== sv/basename_glob_filter_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the basename glob filter
// Shared shorthands for concurrent checks clocked on i_clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef BASENAME_GLOB_FILTER_UNIT_DEFINES_SVH
`define BASENAME_GLOB_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BGF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BGF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bgf_pkg.sv =====
// ---------------------------------------------------------------------------
// Basename glob filter package
// Character codes, register indexes and the types shared by cells and top.
// ---------------------------------------------------------------------------
package bgf_pkg;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_PATH = 1'b1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int LEN_W      = 6;
    localparam int INDEX_W    = 5;
    localparam int DEPTH_W    = 7;
    localparam int ETYPE_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NAME_ENABLE     = 3'd0,
        REG_PATTERN_LENGTH  = 3'd1,
        REG_TYPE_ENABLE     = 3'd2,
        REG_TYPE_WANTED     = 3'd3,
        REG_MINDEPTH_ENABLE = 3'd4,
        REG_MIN_DEPTH       = 3'd5
    } t_cfg_reg;

    // What every cell does with its active flag this cycle.
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_ADV,
        ACT_START
    } t_act_mode;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic               wr;
        logic [INDEX_W-1:0] wr_index;
        logic [7:0]         wr_data;
        t_act_mode          mode;
    } t_bcast;

    // What a cell hands to its neighbors and to the top level.
    typedef struct packed {
        logic hit1;     // next position becomes active
        logic hit2;     // position after next becomes active (escaped byte)
        logic acarry;   // star closure carry on the advanced vector
        logic scarry;   // star closure carry on the start vector
        logic adv_cl;   // this position after advance and closure
        logic start_cl; // this position after restart and closure
    } t_cell_io;

endpackage

// ===== sv/bgf_cell.sv =====
// ---------------------------------------------------------------------------
// Basename glob filter cell
// Holds one pattern byte and the active flag of its pattern position.
// ---------------------------------------------------------------------------
module bgf_cell #(
    parameter int CELL_ID = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bgf_pkg::t_bcast  i_bc,
    input  logic [7:0]       i_path_byte,
    input  bgf_pkg::t_cell_io i_prev,
    input  logic             i_prev2_hit2,
    input  logic [7:0]       i_next_byte,
    input  logic             i_in_use,
    input  logic             i_in_use_next,
    output bgf_pkg::t_cell_io o_io,
    output logic [7:0]       o_byte,
    output logic             o_act
);

    logic [7:0] r_pat;
    logic [7:0] n_pat;
    logic       r_act;
    logic       n_act;
    logic       w_wr_here;
    logic       w_en;
    logic       w_star;
    logic       w_star_n;
    logic       w_esc;
    logic       w_hold;
    logic       w_base;
    logic       w_adv_cl;
    logic       w_start_cl;

    assign w_wr_here = i_bc.wr && (int'(i_bc.wr_index) == CELL_ID);
    assign n_pat     = w_wr_here ? i_bc.wr_data : r_pat;

    // Matching step from the current closed state.
    assign w_en   = r_act && i_in_use;
    assign w_star = (r_pat == bgf_pkg::CH_STAR);
    assign w_esc  = (r_pat == bgf_pkg::CH_BSLASH) && i_in_use_next;
    assign w_hold = w_en && w_star;

    assign o_io.hit1 = w_en && !w_star
                     && ((r_pat == bgf_pkg::CH_QUEST) || (!w_esc && (r_pat == i_path_byte)));
    assign o_io.hit2 = w_en && w_esc && (i_next_byte == i_path_byte);

    // Star closure uses the pattern as it stands after this edge.
    assign w_star_n   = (n_pat == bgf_pkg::CH_STAR);
    assign w_base     = w_hold || i_prev.hit1 || i_prev2_hit2;
    assign w_adv_cl   = w_base || i_prev.acarry;
    assign w_start_cl = (CELL_ID == 0) || i_prev.scarry;

    assign o_io.acarry   = w_adv_cl && w_star_n && i_in_use;
    assign o_io.scarry   = w_start_cl && w_star_n && i_in_use;
    assign o_io.adv_cl   = w_adv_cl;
    assign o_io.start_cl = w_start_cl;

    always_comb begin
        unique case (i_bc.mode)
            bgf_pkg::ACT_ADV:   n_act = w_adv_cl;
            bgf_pkg::ACT_START: n_act = w_start_cl;
            default:            n_act = r_act;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= (CELL_ID == 0);
        end else begin
            r_act <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
    end

    assign o_byte = r_pat;
    assign o_act  = r_act;

endmodule

// ===== sv/basename_glob_filter_unit.sv =====
// ---------------------------------------------------------------------------
// Basename glob filter
// Streams path bytes against a stored glob pattern and flags matching entries.
// ---------------------------------------------------------------------------
// The block accepts one item per clock cycle as long as results are taken, and
// gives a match result through its output buffer for the item that carries the last byte of
// a path. The input stalls only while two results wait, one in the output
// register and one in the skid entry. An
// item either loads one pattern byte into the store or feeds one path byte.
// The pattern lives in a row of PATTERN_BYTES cells; each cell keeps one
// pattern byte and the active flag of its position, and the whole active set
// advances once per path byte with no backtracking. The figure of one item per
// cycle is set by the star closure, which ripples across the row of cells like
// an adder carry chain of PATTERN_BYTES stages; the active set is always kept
// in closed form so that only one such chain lies in the path of each byte.
// A '/' byte restarts matching, so only the basename is tested. Pattern rules:
// '*' takes any run of bytes, '?' takes one byte, a backslash makes the next
// pattern byte literal, and a lone backslash at the end stands for itself.
// The pattern store has no reset and needs no clearing pass; only positions
// below pattern_length are ever read. Results go through a two-entry output
// buffer, so items keep flowing while a result waits to be taken. The
// configuration channel is always ready and must only be written while the
// block is idle; a write of pattern_length also restarts matching.
// ---------------------------------------------------------------------------
`include "basename_glob_filter_unit_defines.svh"

module basename_glob_filter_unit #(
    parameter int PATTERN_BYTES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bgf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bgf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input item channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_action,
    input  logic [bgf_pkg::INDEX_W-1:0]      i_pattern_index,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_path_last,
    input  logic [bgf_pkg::ETYPE_W-1:0]      i_entry_type,
    input  logic [bgf_pkg::DEPTH_W-1:0]      i_entry_depth,
    // Result item channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_matched
);

    localparam int USED_W = (PATTERN_BYTES < 2) ? 1 : $clog2(PATTERN_BYTES + 1);

    // Configuration registers.
    logic                        r_name_enable;
    logic [bgf_pkg::LEN_W-1:0]   r_pattern_length;
    logic [bgf_pkg::LEN_W-1:0]   n_pattern_length;
    logic                        r_type_enable;
    logic [bgf_pkg::ETYPE_W-1:0] r_type_wanted;
    logic                        r_mindepth_enable;
    logic [bgf_pkg::DEPTH_W-1:0] r_min_depth;

    logic w_cfg_acc;
    logic w_len_wr;
    logic w_in_acc;
    logic w_slash;
    logic w_result;

    bgf_pkg::t_bcast   w_bc;
    bgf_pkg::t_cell_io w_io   [PATTERN_BYTES];
    logic [7:0]        w_byte [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] w_act;
    logic [PATTERN_BYTES-1:0] w_in_use;
    logic [PATTERN_BYTES:0]   w_acl;
    logic [PATTERN_BYTES:0]   w_scl;
    logic [PATTERN_BYTES:0]   w_sel;
    logic [USED_W-1:0]        w_used;
    logic                     w_accept;
    logic                     n_match;

    // Output buffer: the output register plus one skid entry.
    logic r_out_valid;
    logic r_out_match;
    logic r_skid_valid;
    logic r_skid_match;
    logic w_pop;

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_len_wr    = w_cfg_acc
                       && (bgf_pkg::t_cfg_reg'(i_cfg_index) == bgf_pkg::REG_PATTERN_LENGTH);
    assign n_pattern_length = w_len_wr ? i_cfg_data[bgf_pkg::LEN_W-1:0] : r_pattern_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_enable     <= 1'b0;
            r_pattern_length  <= '0;
            r_type_enable     <= 1'b0;
            r_type_wanted     <= '0;
            r_mindepth_enable <= 1'b0;
            r_min_depth       <= '0;
        end else if (w_cfg_acc) begin
            unique case (bgf_pkg::t_cfg_reg'(i_cfg_index))
                bgf_pkg::REG_NAME_ENABLE:     r_name_enable     <= i_cfg_data[0];
                bgf_pkg::REG_PATTERN_LENGTH:  r_pattern_length  <= n_pattern_length;
                bgf_pkg::REG_TYPE_ENABLE:     r_type_enable     <= i_cfg_data[0];
                bgf_pkg::REG_TYPE_WANTED:     r_type_wanted     <= i_cfg_data[bgf_pkg::ETYPE_W-1:0];
                bgf_pkg::REG_MINDEPTH_ENABLE: r_mindepth_enable <= i_cfg_data[0];
                bgf_pkg::REG_MIN_DEPTH:       r_min_depth       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Item control: decide what the row of cells does this cycle.
    // ---------------------------------------------------------------------
    assign o_in_ready = !r_skid_valid;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_slash    = (i_data_byte == bgf_pkg::CH_SLASH);
    assign w_result   = w_in_acc && (i_action == bgf_pkg::ACTION_PATH) && i_path_last;

    always_comb begin
        w_bc.wr       = w_in_acc && (i_action == bgf_pkg::ACTION_LOAD);
        w_bc.wr_index = i_pattern_index;
        w_bc.wr_data  = i_data_byte;
        w_bc.mode     = bgf_pkg::ACT_HOLD;
        if (w_in_acc) begin
            if (i_action == bgf_pkg::ACTION_LOAD || i_path_last || w_slash) begin
                w_bc.mode = bgf_pkg::ACT_START;
            end else begin
                w_bc.mode = bgf_pkg::ACT_ADV;
            end
        end else if (w_len_wr) begin
            w_bc.mode = bgf_pkg::ACT_START;
        end
    end

    // ---------------------------------------------------------------------
    // Row of cells. Position PATTERN_BYTES has no cell: it only ever feeds
    // the accept test and never passes anything on.
    // ---------------------------------------------------------------------
    for (genvar g = 0; g < PATTERN_BYTES; g++) begin : g_cell
        bgf_pkg::t_cell_io w_prev;
        logic              w_prev2_hit2;
        logic [7:0]        w_next_byte;
        logic              w_in_use_next;

        assign w_in_use[g] = (int'(n_pattern_length) > g);

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_io[g-1];
        end

        if (g < 2) begin : g_no_prev2
            assign w_prev2_hit2 = 1'b0;
        end else begin : g_prev2
            assign w_prev2_hit2 = w_io[g-2].hit2;
        end

        if (g == PATTERN_BYTES - 1) begin : g_last
            assign w_next_byte   = '0;
            assign w_in_use_next = 1'b0;
        end else begin : g_inner
            assign w_next_byte   = w_byte[g+1];
            assign w_in_use_next = w_in_use[g+1];
        end

        bgf_cell #(
            .CELL_ID (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_bc          (w_bc),
            .i_path_byte   (i_data_byte),
            .i_prev        (w_prev),
            .i_prev2_hit2  (w_prev2_hit2),
            .i_next_byte   (w_next_byte),
            .i_in_use      (w_in_use[g]),
            .i_in_use_next (w_in_use_next),
            .o_io          (w_io[g]),
            .o_byte        (w_byte[g]),
            .o_act         (w_act[g])
        );

        assign w_acl[g] = w_io[g].adv_cl;
        assign w_scl[g] = w_io[g].start_cl;
    end

    if (PATTERN_BYTES < 2) begin : g_end_short
        assign w_acl[PATTERN_BYTES] = w_io[PATTERN_BYTES-1].hit1
                                    || w_io[PATTERN_BYTES-1].acarry;
    end else begin : g_end_long
        assign w_acl[PATTERN_BYTES] = w_io[PATTERN_BYTES-1].hit1
                                    || w_io[PATTERN_BYTES-2].hit2
                                    || w_io[PATTERN_BYTES-1].acarry;
    end
    assign w_scl[PATTERN_BYTES] = w_io[PATTERN_BYTES-1].scarry;

    // ---------------------------------------------------------------------
    // Result of the last byte: the glob test reads the closed active set at
    // the position just past the pattern in use, and the entry filters join.
    // ---------------------------------------------------------------------
    assign w_used   = (int'(r_pattern_length) > PATTERN_BYTES) ? USED_W'(PATTERN_BYTES)
                                                               : USED_W'(r_pattern_length);
    assign w_sel    = w_slash ? w_scl : w_acl;
    assign w_accept = w_sel[w_used];

    assign n_match = !(r_mindepth_enable && (i_entry_depth < r_min_depth))
                  && !(r_name_enable && !w_accept)
                  && !(r_type_enable && (i_entry_type != r_type_wanted));

    // ---------------------------------------------------------------------
    // Output buffer. A new item is taken as long as the skid entry is free.
    // ---------------------------------------------------------------------
    assign w_pop = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= w_result;
            end else begin
                r_out_valid  <= w_result;
                r_skid_valid <= 1'b0;
            end
        end else if (w_result) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            r_out_match  <= r_skid_valid ? r_skid_match : n_match;
            r_skid_match <= n_match;
        end else if (w_result) begin
            r_skid_match <= n_match;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_out_match;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `BGF_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid entry holds a result while the output register is empty")
    `BGF_ASSERT_NEXT(a_load_restarts, w_in_acc && (i_action == bgf_pkg::ACTION_LOAD),
        w_act[0], "start position not active after a pattern load")
    `BGF_ASSERT_NEXT(a_slash_restarts,
        w_in_acc && (i_action == bgf_pkg::ACTION_PATH) && w_slash,
        w_act[0], "start position not active after a slash byte")
    `BGF_ASSERT_NEXT(a_result_shown, w_result && !r_out_valid, o_out_valid,
        "result of a last path byte did not reach the output register")

endmodule

// ===== dv/basename_glob_filter_checker.sv =====
// ---------------------------------------------------------------------------
// Basename glob filter checker
// Watches the configuration, input and result channels of the glob filter,
// keeps its own copy of the pattern store, the active positions and the
// registers, predicts the match flag of every finished path and compares it
// with the result items that the block gives.
// ---------------------------------------------------------------------------
module basename_glob_filter_checker #(
    parameter int PATTERN_BYTES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [bgf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bgf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic                             i_action,
    input  logic [bgf_pkg::INDEX_W-1:0]      i_pattern_index,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_path_last,
    input  logic [bgf_pkg::ETYPE_W-1:0]      i_entry_type,
    input  logic [bgf_pkg::DEPTH_W-1:0]      i_entry_depth,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_matched,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam logic [PATTERN_BYTES:0] START_POS = {{PATTERN_BYTES{1'b0}}, 1'b1};

    logic [7:0]                      glob_store [PATTERN_BYTES];
    logic [PATTERN_BYTES:0]          live_pos;
    logic                            name_on;
    logic [bgf_pkg::LEN_W-1:0]       glob_len;
    logic                            type_on;
    logic [bgf_pkg::ETYPE_W-1:0]     type_want;
    logic                            depth_on;
    logic [bgf_pkg::DEPTH_W-1:0]     depth_min;
    logic                            match_q [$];
    logic                            match_want;
    int                              fail_total = 0;

    // Lengths above the store size saturate.
    function automatic int used_len();
        return (int'(glob_len) > PATTERN_BYTES) ? PATTERN_BYTES : int'(glob_len);
    endfunction

    // An active star also activates the position right after it.
    function automatic logic [PATTERN_BYTES:0] close_stars(input logic [PATTERN_BYTES:0] v);
        int n;
        n = used_len();
        for (int i = 0; i < n; i++)
            if (v[i] && glob_store[i] == bgf_pkg::CH_STAR)
                v[i+1] = 1'b1;
        return v;
    endfunction

    function automatic logic [PATTERN_BYTES:0] next_pos(input logic [7:0] c);
        logic [PATTERN_BYTES:0] cur;
        logic [PATTERN_BYTES:0] nxt;
        int n;
        n   = used_len();
        cur = close_stars(live_pos);
        nxt = '0;
        for (int i = 0; i < n; i++) begin
            if (!cur[i])
                continue;
            if (glob_store[i] == bgf_pkg::CH_STAR) begin
                nxt[i] = 1'b1;
            end else if (glob_store[i] == bgf_pkg::CH_QUEST) begin
                nxt[i+1] = 1'b1;
            end else if (glob_store[i] == bgf_pkg::CH_BSLASH && i + 1 < n) begin
                if (glob_store[i+1] == c)
                    nxt[i+2] = 1'b1;
            end else if (glob_store[i] == c) begin
                nxt[i+1] = 1'b1;
            end
        end
        return nxt;
    endfunction

    function automatic logic entry_passes(input logic [bgf_pkg::ETYPE_W-1:0] et,
                                          input logic [bgf_pkg::DEPTH_W-1:0] dep);
        logic [PATTERN_BYTES:0] cl;
        logic ok;
        cl = close_stars(live_pos);
        ok = 1'b1;
        if (depth_on && dep < depth_min)
            ok = 1'b0;
        if (name_on && !cl[used_len()])
            ok = 1'b0;
        if (type_on && et != type_want)
            ok = 1'b0;
        return ok;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            live_pos  = START_POS;
            name_on   = 1'b0;
            glob_len  = '0;
            type_on   = 1'b0;
            type_want = '0;
            depth_on  = 1'b0;
            depth_min = '0;
            match_q.delete();
        end else begin
            // Results first: one taken at this edge belongs to an earlier item.
            if (i_out_valid && i_out_ready) begin
                if (match_q.size() == 0) begin
                    $display("%0t: result with none waiting: expected none, actual matched=%0b",
                             $time, i_matched);
                    fail_total++;
                end else begin
                    match_want = match_q.pop_front();
                    if (i_matched !== match_want) begin
                        $display("%0t: matched mismatch: expected %0b, actual %0b",
                                 $time, match_want, i_matched);
                        fail_total++;
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bgf_pkg::REG_NAME_ENABLE:     name_on = i_cfg_data[0];
                    bgf_pkg::REG_PATTERN_LENGTH: begin
                        glob_len = i_cfg_data[bgf_pkg::LEN_W-1:0];
                        live_pos = START_POS;
                    end
                    bgf_pkg::REG_TYPE_ENABLE:     type_on = i_cfg_data[0];
                    bgf_pkg::REG_TYPE_WANTED:     type_want = i_cfg_data[bgf_pkg::ETYPE_W-1:0];
                    bgf_pkg::REG_MINDEPTH_ENABLE: depth_on = i_cfg_data[0];
                    bgf_pkg::REG_MIN_DEPTH:       depth_min = i_cfg_data[bgf_pkg::DEPTH_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                if (i_action == bgf_pkg::ACTION_LOAD) begin
                    if (int'(i_pattern_index) < PATTERN_BYTES)
                        glob_store[int'(i_pattern_index)] = i_data_byte;
                    live_pos = START_POS;
                end else begin
                    live_pos = (i_data_byte == bgf_pkg::CH_SLASH) ? START_POS
                                                                  : next_pos(i_data_byte);
                    if (i_path_last) begin
                        match_q.push_back(entry_passes(i_entry_type, i_entry_depth));
                        live_pos = START_POS;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= match_q.size();
    end

endmodule

// ===== dv/tb_basename_glob_filter_unit.sv =====
// ---------------------------------------------------------------------------
// Basename glob filter testbench
// Drives pattern loads, register writes and streamed paths into the filter
// with random gaps and result stalls; a checker beside the block predicts
// each match flag and counts mismatches, and this top gives the verdict.
// ---------------------------------------------------------------------------
module tb_basename_glob_filter_unit;

    localparam int PAT_BYTES     = 32;
    localparam int DEPTH_MAX     = 64;
    localparam int TYPE_MAX      = 3;
    localparam int LEN_REG_MAX   = (1 << bgf_pkg::LEN_W) - 1;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 40;
    localparam int SETTLE_CYCLES = 4;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [bgf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [bgf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // A few plain name bytes that make matches likely.
    localparam logic [7:0] BYTE_A   = 8'h61;
    localparam logic [7:0] BYTE_B   = 8'h62;
    localparam logic [7:0] BYTE_DOT = 8'h2E;

    typedef logic [7:0] t_bytes [$];

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic [bgf_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [bgf_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                               i_in_valid = 1'b0;
    logic                               i_action = 1'b0;
    logic [bgf_pkg::INDEX_W-1:0]        i_pattern_index = '0;
    logic [7:0]                         i_data_byte = '0;
    logic                               i_path_last = 1'b0;
    logic [bgf_pkg::ETYPE_W-1:0]        i_entry_type = '0;
    logic [bgf_pkg::DEPTH_W-1:0]        i_entry_depth = '0;
    logic                               i_out_ready = 1'b0;
    logic                               o_cfg_ready;
    logic                               o_in_ready;
    logic                               o_out_valid;
    logic                               o_matched;

    int                     fail_count;
    int                     pending;

    // The stimulus keeps its own copy of the pattern so that it can build
    // paths that match it.
    logic [7:0]             pat_copy [PAT_BYTES];
    int                     cur_len = 0;
    int                     cur_min_depth = 0;

    // Set for the closing part of the run: no gaps and no stalls there.
    bit                     calm_tail = 1'b0;
    int                     stall_left = 0;

    basename_glob_filter_unit #(
        .PATTERN_BYTES (PAT_BYTES)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_pattern_index (i_pattern_index),
        .i_data_byte     (i_data_byte),
        .i_path_last     (i_path_last),
        .i_entry_type    (i_entry_type),
        .i_entry_depth   (i_entry_depth),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_matched       (o_matched)
    );

    basename_glob_filter_checker #(
        .PATTERN_BYTES (PAT_BYTES)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_pattern_index (i_pattern_index),
        .i_data_byte     (i_data_byte),
        .i_path_last     (i_path_last),
        .i_entry_type    (i_entry_type),
        .i_entry_depth   (i_entry_depth),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_matched       (o_matched),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #5 i_clk = ~i_clk;

    // The result side stalls in random bursts. Ready is held
    // high during reset and for the whole closing part of the run.
    always @(negedge i_clk) begin
        if (calm_tail || !i_rst_n) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 3);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // A byte drawn with weight on the glob metacharacters, the slash, the
    // extreme values and a few letters, so that stars and escapes meet real
    // data often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return BYTE_A;
            1:       return BYTE_B;
            2:       return BYTE_DOT;
            3:       return bgf_pkg::CH_STAR;
            4:       return bgf_pkg::CH_QUEST;
            5:       return bgf_pkg::CH_BSLASH;
            6:       return bgf_pkg::CH_SLASH;
            7:       return 8'h00;
            8:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Same, but never a slash; used inside a basename.
    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        b = pick_byte();
        return (b == bgf_pkg::CH_SLASH) ? BYTE_A : b;
    endfunction

    // One item on the input channel. A random gap may come first; after the
    // call returns the item has been accepted and valid is still high, so a
    // following item goes out back to back.
    task automatic send_item(input int act, input int idx, input int b, input int last,
                             input int et, input int dep);
        int gap;
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_action        <= act[0];
        i_pattern_index <= idx[bgf_pkg::INDEX_W-1:0];
        i_data_byte     <= b[7:0];
        i_path_last     <= last[0];
        i_entry_type    <= et[bgf_pkg::ETYPE_W-1:0];
        i_entry_depth   <= dep[bgf_pkg::DEPTH_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Pattern loads carry random values in the fields that the block ignores.
    task automatic load_byte(input int idx, input logic [7:0] b);
        send_item(bgf_pkg::ACTION_LOAD, idx, b, $urandom_range(0, 1),
                  $urandom_range(0, TYPE_MAX), $urandom_range(0, DEPTH_MAX));
        pat_copy[idx] = b;
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            load_byte(i, s[i]);
    endtask

    // Streams a whole path; entry type and depth only count on the last byte.
    task automatic feed_path(input t_bytes p, input int et, input int dep);
        foreach (p[i]) begin
            if (i == p.size() - 1)
                send_item(bgf_pkg::ACTION_PATH, $urandom_range(0, PAT_BYTES - 1), p[i], 1,
                          et, dep);
            else
                send_item(bgf_pkg::ACTION_PATH, $urandom_range(0, PAT_BYTES - 1), p[i], 0,
                          $urandom_range(0, TYPE_MAX), $urandom_range(0, DEPTH_MAX));
        end
    endtask

    task automatic send_text(input string s, input int et, input int dep);
        t_bytes p;
        for (int i = 0; i < s.len(); i++)
            p.push_back(s[i]);
        feed_path(p, et, dep);
    endtask

    // Drops valid, waits until every expected result is back, then lets the
    // pipeline drain so that registers can be written.
    task automatic settle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bgf_pkg::CFG_IDX_W-1:0] r, input int v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v[bgf_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Builds a path whose basename should match the current pattern: a star
    // becomes zero to two bytes, a question mark one byte, an escape its
    // literal. Some paths get a leading directory, and some get spoiled by a
    // changed, dropped or extra byte.
    task automatic derive_path(output t_bytes p);
        int i;
        logic [7:0] b;
        p = {};
        if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 3)) p.push_back(name_byte());
            p.push_back(bgf_pkg::CH_SLASH);
        end
        i = 0;
        while (i < cur_len) begin
            b = pat_copy[i];
            if (b == bgf_pkg::CH_STAR) begin
                repeat ($urandom_range(0, 2)) p.push_back(name_byte());
                i++;
            end else if (b == bgf_pkg::CH_QUEST) begin
                p.push_back(name_byte());
                i++;
            end else if (b == bgf_pkg::CH_BSLASH && i + 1 < cur_len) begin
                p.push_back(pat_copy[i+1]);
                i += 2;
            end else begin
                p.push_back(b);
                i++;
            end
        end
        case ($urandom_range(0, 7))
            0: if (p.size() > 0) p[$urandom_range(0, p.size() - 1)] = pick_byte();
            1: if (p.size() > 0) void'(p.pop_back());
            2: p.push_back(name_byte());
            default: ;
        endcase
        // A path needs at least one byte; a lone slash leaves an empty basename.
        if (p.size() == 0)
            p.push_back(bgf_pkg::CH_SLASH);
    endtask

    initial begin : stimulus
        t_bytes     path;
        int         plen;
        int         len_reg;
        int         count;
        int         r;
        int         dep;
        logic [7:0] b;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // ---------------- directed part ----------------
        // All filters off after reset: every entry matches.
        send_text("a", TYPE_MAX, 0);

        // Star suffix; a slash restarts matching, and a path that ends in a
        // slash leaves an empty basename that the suffix cannot match.
        load_text("*.c");
        settle();
        write_reg(bgf_pkg::REG_NAME_ENABLE, 1);
        write_reg(bgf_pkg::REG_PATTERN_LENGTH, 3);
        send_text("x/y.c", 0, 1);
        send_text("/", 1, 0);

        // Question mark, an escaped star, and a lone backslash at the end of
        // the pattern that stands for itself.
        load_text("?\\*\\");
        settle();
        write_reg(bgf_pkg::REG_PATTERN_LENGTH, 4);
        send_text("z*\\", 2, 5);

        // A pattern of one star takes the empty basename. Type filter on the
        // "other" type and a minimum depth of DEPTH_MAX: exactly at the limit
        // passes, one below and the wrong type fails. An unknown register
        // index is written with all ones and must change nothing.
        load_text("*");
        settle();
        write_reg(bgf_pkg::REG_PATTERN_LENGTH, 1);
        write_reg(bgf_pkg::REG_TYPE_ENABLE, 1);
        write_reg(bgf_pkg::REG_TYPE_WANTED, TYPE_MAX);
        write_reg(bgf_pkg::REG_MINDEPTH_ENABLE, 1);
        write_reg(bgf_pkg::REG_MIN_DEPTH, DEPTH_MAX);
        write_reg(REG_SPARE_HI, (1 << bgf_pkg::CFG_DATA_W) - 1);
        send_text("ab/", TYPE_MAX, DEPTH_MAX);
        send_text("x", 2, DEPTH_MAX - 1);
        settle();

        // ---------------- random part ----------------
        // Each phase loads a fresh pattern, picks new register values while
        // the block is idle, and then streams paths mostly built to match.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph >= PHASES - 2)
                calm_tail = 1'b1;

            // The first phase fills the whole store and writes the largest
            // length so that it saturates; the second runs an empty pattern.
            if (ph == 0)
                plen = PAT_BYTES;
            else if (ph == 1)
                plen = 0;
            else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: plen = $urandom_range(1, 6);
                    7, 8:                plen = $urandom_range(7, 16);
                    default:             plen = PAT_BYTES;
                endcase
            end

            for (int i = 0; i < plen; i++) begin
                b = pick_byte();
                // Slashes in a pattern never match; keep them uncommon.
                if (b == bgf_pkg::CH_SLASH && $urandom_range(0, 3) != 0)
                    b = BYTE_A;
                load_byte(i, b);
            end
            settle();

            len_reg = plen;
            if (plen == PAT_BYTES)
                len_reg = (ph == 0) ? LEN_REG_MAX : $urandom_range(PAT_BYTES, LEN_REG_MAX);
            cur_len = plen;

            case ($urandom_range(0, 3))
                0:       cur_min_depth = 0;
                1:       cur_min_depth = DEPTH_MAX;
                default: cur_min_depth = $urandom_range(0, DEPTH_MAX);
            endcase

            write_reg(bgf_pkg::REG_PATTERN_LENGTH, len_reg);
            write_reg(bgf_pkg::REG_NAME_ENABLE, int'($urandom_range(0, 4) != 0));
            write_reg(bgf_pkg::REG_TYPE_ENABLE, int'($urandom_range(0, 2) == 0));
            write_reg(bgf_pkg::REG_TYPE_WANTED, $urandom_range(0, TYPE_MAX));
            write_reg(bgf_pkg::REG_MINDEPTH_ENABLE, int'($urandom_range(0, 2) == 0));
            write_reg(bgf_pkg::REG_MIN_DEPTH, cur_min_depth);
            if (ph == 2)
                write_reg(REG_SPARE_LO, $urandom_range(0, (1 << bgf_pkg::CFG_DATA_W) - 1));

            count = 0;
            while (count < PHASE_ITEMS) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    // A pattern byte rewritten between paths restarts matching.
                    load_byte($urandom_range(0, PAT_BYTES - 1), pick_byte());
                    count++;
                end else if (r == 1) begin
                    // Hold off the sender until every result is back.
                    settle();
                end else begin
                    if (r <= 4) begin
                        path = {};
                        repeat ($urandom_range(1, 6)) path.push_back(pick_byte());
                    end else begin
                        derive_path(path);
                    end
                    // Depths cluster at the minimum so both sides of it occur.
                    case ($urandom_range(0, 3))
                        0:       dep = cur_min_depth;
                        1:       dep = (cur_min_depth == 0) ? 0 : cur_min_depth - 1;
                        default: dep = $urandom_range(0, DEPTH_MAX);
                    endcase
                    feed_path(path, $urandom_range(0, TYPE_MAX), dep);
                    count += path.size();
                end
            end
            settle();
        end

        // settle() above has already waited out every expected result.
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Far beyond the slowest correct run, even with every gap and stall at
    // its longest.
    initial begin : watchdog
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
